@@ hw/rtl/cidr_pkg.sv @@
// Shared types, widths and codes for the prefix membership table.
// No dependencies; every other file of the block depends on this package.
package cidr_pkg;

    // Table size and field widths
    localparam int TABLE_ENTRIES = 16;
    localparam int INDEX_W       = 4;
    localparam int PREFIX_W      = 8;
    localparam int HALF_W        = 64;
    localparam int ADDR_W        = 2 * HALF_W;
    // Cell id wide enough to hold any index of the chain
    localparam int CELL_ID_W     = $clog2(TABLE_ENTRIES + 1);

    // Operation codes
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    // Address families
    localparam logic FAM_IPV4 = 1'b0;
    localparam logic FAM_IPV6 = 1'b1;

    localparam logic [PREFIX_W-1:0] IPV4_MAX_PREFIX = PREFIX_W'(32);

    // Word carried from cell to cell: the request plus the running result
    typedef struct packed {
        logic                opcode;
        logic [INDEX_W-1:0]  entry_index;
        logic                entry_valid;
        logic                family;
        logic [PREFIX_W-1:0] prefix_length;
        logic [HALF_W-1:0]   address_high;
        logic [HALF_W-1:0]   address_low;
        logic                hit;
        logic [INDEX_W-1:0]  match_index;
    } word_t;

    // Mask of the top prefix bits of a 128-bit address.
    // IPv4 caps at 32; a shift of 128 or more yields a full mask.
    function automatic logic [ADDR_W-1:0] prefix_mask(
        input logic                fam,
        input logic [PREFIX_W-1:0] plen
    );
        logic [PREFIX_W-1:0] eff;
        eff = plen;
        if (fam == FAM_IPV4 && plen > IPV4_MAX_PREFIX)
        begin
            eff = IPV4_MAX_PREFIX;
        end
        return ~({ADDR_W{1'b1}} >> eff);
    endfunction

endpackage

@@ hw/rtl/cidr_if.sv @@
// Request and response channels of the prefix membership table.
// Depends on cidr_pkg for field widths.
interface cidr_req_if;
    logic                            valid;
    logic                            ready;
    logic                            opcode;
    logic [cidr_pkg::INDEX_W-1:0]    entry_index;
    logic                            entry_valid;
    logic                            family;
    logic [cidr_pkg::PREFIX_W-1:0]   prefix_length;
    logic [cidr_pkg::HALF_W-1:0]     address_high;
    logic [cidr_pkg::HALF_W-1:0]     address_low;

    modport source (
        output valid, opcode, entry_index, entry_valid, family, prefix_length,
               address_high, address_low,
        input  ready
    );
    modport sink (
        input  valid, opcode, entry_index, entry_valid, family, prefix_length,
               address_high, address_low,
        output ready
    );
endinterface

interface cidr_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            hit;
    logic [cidr_pkg::INDEX_W-1:0]    match_index;

    modport source (
        output valid, hit, match_index,
        input  ready
    );
    modport sink (
        input  valid, hit, match_index,
        output ready
    );
endinterface

@@ hw/rtl/cidr_cell.sv @@
// One table cell: holds a single prefix entry and the pipeline register
// toward its neighbor. Depends on cidr_pkg.
module cidr_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  logic [cidr_pkg::CELL_ID_W-1:0] cell_id,
    input  logic                           in_valid,
    input  cidr_pkg::word_t                in_word,
    output logic                           out_valid,
    output cidr_pkg::word_t                out_word
);
    import cidr_pkg::*;

    logic                entry_valid_reg;
    logic                entry_family_reg;
    logic [PREFIX_W-1:0] entry_prefix_reg;
    logic [ADDR_W-1:0]   entry_addr_reg;

    logic                out_valid_reg;
    word_t               out_word_reg;
    word_t               out_word_next;

    logic                id_match;
    logic                write_en;
    logic                entry_hit;
    logic [ADDR_W-1:0]   mask;
    logic [ADDR_W-1:0]   lookup_addr;

    // Write decode against this cell's slot
    assign id_match = (32'(in_word.entry_index) == 32'(cell_id));
    assign write_en = advance && in_valid && (in_word.opcode == OP_WRITE) && id_match;

    // Prefix compare of the passing lookup against the stored entry
    assign mask        = prefix_mask(entry_family_reg, entry_prefix_reg);
    assign lookup_addr = {in_word.address_high, in_word.address_low};
    assign entry_hit   = (in_word.opcode == OP_LOOKUP) && entry_valid_reg
                         && (entry_family_reg == in_word.family)
                         && (((lookup_addr ^ entry_addr_reg) & mask) == '0);

    // First hit along the chain wins, so earlier cells keep the lowest index
    always_comb
    begin
        out_word_next = in_word;
        if (entry_hit && !in_word.hit)
        begin
            out_word_next.hit         = 1'b1;
            out_word_next.match_index = INDEX_W'(cell_id);
        end
    end

    // Valid marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (write_en)
            begin
                entry_valid_reg <= in_word.entry_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid;
            end
        end
    end

    // Entry contents and forwarded word
    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            entry_family_reg <= in_word.family;
            entry_prefix_reg <= in_word.prefix_length;
            entry_addr_reg   <= lookup_addr;
        end
        if (advance)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // A write word never leaves a cell carrying a hit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_word_reg.opcode == OP_WRITE) |-> !out_word_reg.hit)
        else $error("write word carries a hit");

    // A hit found upstream is kept with its index
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_valid && in_word.hit
        |=> out_word_reg.hit && (out_word_reg.match_index == $past(in_word.match_index)))
        else $error("upstream hit lost or altered");

    // The stored valid mark changes only through a write to this slot
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(entry_valid_reg) |-> $past(write_en))
        else $error("entry valid changed without a write");

endmodule

@@ hw/rtl/cidr_network_membership_table_unit.sv @@
// Prefix membership table built as a chain of TABLE_ENTRIES cells, one per
// slot. Each request word enters cell 0 and moves one cell per clock; a write
// loads the cell whose slot it names, a lookup collects the lowest matching
// slot on its way. One word is accepted per clock and its response is read
// from the output register of the last cell, at the far end of the cell chain.
// Words stay in order, so a lookup always sees every earlier write. When the
// response is not taken the whole chain holds. Depends on cidr_pkg, cidr_if
// and cidr_cell.
module cidr_network_membership_table_unit (
    input  logic        clk,
    input  logic        rst_n,
    cidr_req_if.sink    req,
    cidr_rsp_if.source  rsp
);
    import cidr_pkg::*;

    logic  advance;
    logic  stage_valid [0:TABLE_ENTRIES];
    word_t stage_word  [0:TABLE_ENTRIES];

    // Whole chain moves when the output slot is free or being taken
    assign advance   = !stage_valid[TABLE_ENTRIES] || rsp.ready;
    assign req.ready = advance;

    // Request word into the head of the chain, result cleared
    assign stage_valid[0]              = req.valid;
    assign stage_word[0].opcode        = req.opcode;
    assign stage_word[0].entry_index   = req.entry_index;
    assign stage_word[0].entry_valid   = req.entry_valid;
    assign stage_word[0].family        = req.family;
    assign stage_word[0].prefix_length = req.prefix_length;
    assign stage_word[0].address_high  = req.address_high;
    assign stage_word[0].address_low   = req.address_low;
    assign stage_word[0].hit           = 1'b0;
    assign stage_word[0].match_index   = '0;

    // Cell chain
    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        cidr_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .cell_id   (CELL_ID_W'(i)),
            .in_valid  (stage_valid[i]),
            .in_word   (stage_word[i]),
            .out_valid (stage_valid[i+1]),
            .out_word  (stage_word[i+1])
        );
    end

    // Last cell register is the output register
    assign rsp.valid       = stage_valid[TABLE_ENTRIES];
    assign rsp.hit         = stage_word[TABLE_ENTRIES].hit;
    assign rsp.match_index = stage_word[TABLE_ENTRIES].match_index;

    // A miss always reports index zero
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.hit |-> (rsp.match_index == '0))
        else $error("miss with nonzero index");

endmodule
